[hdl/rau_pkg.sv]
// Package: widths, codes and structs shared by the rational arithmetic unit.
package rau_pkg;

	localparam int WIDTH = 16;
	localparam int DW    = 2 * WIDTH;
	localparam int KW    = $clog2(DW);

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_NEG  = 3'd4,
		CMD_INV  = 3'd5,
		CMD_NORM = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ZDEN = 2'd1,
		STAT_OVF  = 2'd2
	} res_status_t;

	typedef enum logic [3:0] {
		DP_IDLE,
		DP_LOAD,
		DP_PRE_R,
		DP_PRE_L,
		DP_PROD_A,
		DP_PROD_B,
		DP_PROD_D,
		DP_GCD_INIT,
		DP_GCD_STEP,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_FIX_R,
		DP_FIX_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PRE_R,
		S_PRE_L,
		S_PROD_A,
		S_PROD_B,
		S_PROD_D,
		S_RED,
		S_GCD,
		S_DIV,
		S_FIX
	} state_t;

	typedef struct packed {
		logic [2:0]              command;
		logic signed [WIDTH-1:0] left_num;
		logic signed [WIDTH-1:0] left_den;
		logic signed [WIDTH-1:0] right_num;
		logic signed [WIDTH-1:0] right_den;
	} in_t;

	typedef struct packed {
		logic signed [WIDTH-1:0] result_num;
		logic [WIDTH-2:0]        result_den;
		logic [1:0]              status;
	} out_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] cmd;
	} ctl_t;

	typedef struct packed {
		logic any_zero;
		logic gcd_eq;
		logic div_last;
		logic out_full;
	} sts_t;

endpackage

[hdl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: two signed fractions in, one reduced fraction out.
//
// Input channel in_valid/in_ready/in_data carries a command and two fractions.
// Output channel out_valid/out_ready/out_data carries the reduced numerator, the
// nonnegative denominator and a status (ok, zero denominator, overflow).
// One item is worked at a time; in_ready is high only while the block is idle.
// When the numerator or the denominator to reduce is zero, gcd and divide are
// skipped. Otherwise the time to output valid is set by the binary gcd, one step
// per cycle over up to 32-bit magnitudes, followed by a 32-step restoring divide
// of numerator and denominator in parallel.
// Subtract and divide run this reduction twice, first on the right operand alone.
// Cross products use one shared 16x16 multiplier, one product after another.
// The result sits in an output register; the next input beat is accepted while
// it waits. If the receiver stalls, the following item finishes and then holds
// until the register is free.
// Reset clears the controller and the output valid; no result is pending.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	ctl_t ctl;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.command),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	rau_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[hdl/rau_ctrl.sv]
// Controller: sequences load, products, gcd, divide and fix-up for one item.
module rau_ctrl import rau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_cmd,
	output logic       in_ready,
	input  sts_t       sts,
	output ctl_t       ctl
);

	state_t     state_q, state_d;
	logic [2:0] cmd_q, cmd_d;
	logic       pre_q, pre_d;
	logic       add_like;

	assign add_like = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_ADD;
			pre_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
			pre_q   <= pre_d;
		end
	end

	// Next state and datapath command
	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		pre_d    = pre_q;
		in_ready = 1'b0;
		ctl.op   = DP_IDLE;
		ctl.cmd  = cmd_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op = DP_LOAD;
					cmd_d  = in_cmd;
					unique case (in_cmd) inside
						CMD_SUB, CMD_DIV: state_d = S_PRE_R;
						CMD_ADD, CMD_MUL: state_d = S_PROD_A;
						default:          state_d = S_PRE_L;
					endcase
				end
			end
			S_PRE_R: begin
				ctl.op  = DP_PRE_R;
				pre_d   = 1'b1;
				state_d = S_RED;
			end
			S_PRE_L: begin
				ctl.op  = DP_PRE_L;
				pre_d   = 1'b0;
				state_d = S_RED;
			end
			S_PROD_A: begin
				ctl.op  = DP_PROD_A;
				state_d = add_like ? S_PROD_B : S_PROD_D;
			end
			S_PROD_B: begin
				ctl.op  = DP_PROD_B;
				state_d = S_PROD_D;
			end
			S_PROD_D: begin
				ctl.op  = DP_PROD_D;
				pre_d   = 1'b0;
				state_d = S_RED;
			end
			S_RED: begin
				ctl.op  = DP_GCD_INIT;
				state_d = sts.any_zero ? S_FIX : S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_eq) begin
					ctl.op  = DP_DIV_INIT;
					state_d = S_DIV;
				end else begin
					ctl.op = DP_GCD_STEP;
				end
			end
			S_DIV: begin
				ctl.op = DP_DIV_STEP;
				if (sts.div_last) state_d = S_FIX;
			end
			S_FIX: begin
				if (pre_q) begin
					ctl.op  = DP_FIX_R;
					state_d = S_PROD_A;
				end else if (!sts.out_full) begin
					ctl.op  = DP_FIX_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/rau_dp.sv]
// Datapath: operand registers, shared multiplier, binary gcd, dual divider, output beat.
module rau_dp import rau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  in_data,
	input  ctl_t ctl,
	output sts_t sts,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam logic [DW-1:0] HALF = DW'(1) << (WIDTH - 1);

	logic             lnn_q, ldn_q, rnn_q, rdn_q;
	logic [WIDTH-1:0] lnm_q, ldm_q, rnm_q, rdm_q;
	logic [DW-1:0]    m1_q, m2_q;
	logic             wn_neg_q, wd_neg_q;
	logic [DW-1:0]    wn_q, wd_q;
	logic [DW-1:0]    ga_q, gb_q, g_q, rn_q, rd_q;
	logic [KW-1:0]    gk_q, cnt_q;
	out_t             out_q;
	logic             out_valid_q;

	logic [WIDTH-1:0] ma, mb;
	logic [DW-1:0]    prod;
	logic             s1, s2;
	logic [DW:0]      tn, td;
	logic             fx_nneg;
	logic [DW-1:0]    fx_dm;
	logic             fits;
	logic             add_like;

	function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
		return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
	endfunction

	assign add_like = (ctl.cmd == CMD_ADD) || (ctl.cmd == CMD_SUB);

	// Share one multiplier across the three cross products
	always_comb begin
		ma = lnm_q;
		mb = rdm_q;
		case (ctl.op)
			DP_PROD_A: begin
				ma = lnm_q;
				mb = add_like ? rdm_q : rnm_q;
			end
			DP_PROD_B: begin
				ma = rnm_q;
				mb = ldm_q;
			end
			DP_PROD_D: begin
				ma = ldm_q;
				mb = rdm_q;
			end
			default: begin
				ma = lnm_q;
				mb = rdm_q;
			end
		endcase
	end
	assign prod = DW'(ma) * DW'(mb);
	assign s1   = lnn_q ^ rdn_q;
	assign s2   = rnn_q ^ ldn_q;

	// Divider trial subtract
	assign tn = {rn_q, wn_q[DW-1]};
	assign td = {rd_q, wd_q[DW-1]};

	// Move sign to numerator, zero numerator gives 0/1
	always_comb begin
		fx_nneg = wn_neg_q;
		fx_dm   = wd_q;
		if (wd_q != '0 && wd_neg_q) fx_nneg = ~wn_neg_q;
		if (wn_q == '0) begin
			fx_nneg = 1'b0;
			fx_dm   = DW'(1);
		end
		fits = fx_nneg ? (wn_q <= HALF) : (wn_q < HALF);
		if (fx_dm >= HALF) fits = 1'b0;
	end

	assign sts.any_zero = (wn_q == '0) || (wd_q == '0);
	assign sts.gcd_eq   = (ga_q == gb_q);
	assign sts.div_last = (cnt_q == KW'(DW - 1));
	assign sts.out_full = out_valid_q && !out_ready;

	// Operand, work and iteration registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			DP_LOAD: begin
				lnn_q <= in_data.left_num[WIDTH-1];
				lnm_q <= mag_of(in_data.left_num);
				ldn_q <= in_data.left_den[WIDTH-1];
				ldm_q <= mag_of(in_data.left_den);
				rnn_q <= in_data.right_num[WIDTH-1];
				rnm_q <= mag_of(in_data.right_num);
				rdn_q <= in_data.right_den[WIDTH-1];
				rdm_q <= mag_of(in_data.right_den);
			end
			DP_PRE_R: begin
				if (ctl.cmd == CMD_SUB) begin
					wn_neg_q <= ~rnn_q;
					wn_q     <= DW'(rnm_q);
					wd_neg_q <= rdn_q;
					wd_q     <= DW'(rdm_q);
				end else begin
					wn_neg_q <= rdn_q;
					wn_q     <= DW'(rdm_q);
					wd_neg_q <= rnn_q;
					wd_q     <= DW'(rnm_q);
				end
			end
			DP_PRE_L: begin
				case (ctl.cmd)
					CMD_NEG: begin
						wn_neg_q <= ~lnn_q;
						wn_q     <= DW'(lnm_q);
						wd_neg_q <= ldn_q;
						wd_q     <= DW'(ldm_q);
					end
					CMD_INV: begin
						wn_neg_q <= ldn_q;
						wn_q     <= DW'(ldm_q);
						wd_neg_q <= lnn_q;
						wd_q     <= DW'(lnm_q);
					end
					default: begin
						wn_neg_q <= lnn_q;
						wn_q     <= DW'(lnm_q);
						wd_neg_q <= ldn_q;
						wd_q     <= DW'(ldm_q);
					end
				endcase
			end
			DP_PROD_A: begin
				if (add_like) begin
					m1_q <= prod;
				end else begin
					wn_neg_q <= lnn_q ^ rnn_q;
					wn_q     <= prod;
				end
			end
			DP_PROD_B: m2_q <= prod;
			DP_PROD_D: begin
				wd_neg_q <= ldn_q ^ rdn_q;
				wd_q     <= prod;
				if (add_like) begin
					if (s1 == s2) begin
						wn_neg_q <= s1;
						wn_q     <= m1_q + m2_q;
					end else if (m1_q >= m2_q) begin
						wn_neg_q <= s1;
						wn_q     <= m1_q - m2_q;
					end else begin
						wn_neg_q <= s2;
						wn_q     <= m2_q - m1_q;
					end
				end
			end
			DP_GCD_INIT: begin
				ga_q <= wn_q;
				gb_q <= wd_q;
				gk_q <= '0;
			end
			DP_GCD_STEP: begin
				if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + KW'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q > gb_q) begin
					ga_q <= (ga_q - gb_q) >> 1;
				end else begin
					gb_q <= (gb_q - ga_q) >> 1;
				end
			end
			DP_DIV_INIT: begin
				g_q   <= ga_q << gk_q;
				rn_q  <= '0;
				rd_q  <= '0;
				cnt_q <= '0;
			end
			DP_DIV_STEP: begin
				// Shift one quotient bit into each work register
				if (tn >= {1'b0, g_q}) begin
					rn_q <= DW'(tn - {1'b0, g_q});
					wn_q <= {wn_q[DW-2:0], 1'b1};
				end else begin
					rn_q <= tn[DW-1:0];
					wn_q <= {wn_q[DW-2:0], 1'b0};
				end
				if (td >= {1'b0, g_q}) begin
					rd_q <= DW'(td - {1'b0, g_q});
					wd_q <= {wd_q[DW-2:0], 1'b1};
				end else begin
					rd_q <= td[DW-1:0];
					wd_q <= {wd_q[DW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + KW'(1);
			end
			DP_FIX_R: begin
				rnn_q <= fx_nneg;
				rnm_q <= wn_q[WIDTH-1:0];
				rdn_q <= 1'b0;
				rdm_q <= fx_dm[WIDTH-1:0];
			end
			DP_FIX_OUT: begin
				if (fits) begin
					out_q.result_num <= fx_nneg ? (~wn_q[WIDTH-1:0] + WIDTH'(1))
						: wn_q[WIDTH-1:0];
					out_q.result_den <= fx_dm[WIDTH-2:0];
					out_q.status     <= (fx_dm == '0) ? STAT_ZDEN : STAT_OK;
				end else begin
					out_q.result_num <= '0;
					out_q.result_den <= '0;
					out_q.status     <= STAT_OVF;
				end
			end
			default: ;
		endcase
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == DP_FIX_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
